### rtl/core/lfu_pkg.sv
// Shared types and constants for the LFU cache with LRU tie-break.
package lfu_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_COUNT_BITS = 16;
  localparam int SLOT_FIELD_W   = 8;
  localparam int CAP_W          = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_BUMP   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_INSERT = 2'd3
  } lfu_op_t;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Search wave that travels down the row of entry cells.
  typedef struct packed {
    logic                    live;
    logic [31:0]             key;
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] hit_slot;
    logic [31:0]             hit_value;
    logic                    best_ok;
    logic [SLOT_FIELD_W-1:0] best_slot;
    logic [31:0]             best_count;
    logic [63:0]             best_stamp;
    logic                    free_ok;
    logic [SLOT_FIELD_W-1:0] free_slot;
  } lfu_carry_t;

  // Update broadcast to all cells; only the addressed cell acts on it.
  typedef struct packed {
    lfu_op_t                 op;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [31:0]             key;
    logic [31:0]             value;
    logic [63:0]             stamp;
  } lfu_cmd_t;

endpackage

### rtl/core/lfu_in_if.sv
// Input channel: one cache operation per transaction.
interface lfu_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] key;
  logic signed [31:0] value;
  modport source (output valid, func, key, value, input ready);
  modport sink   (input valid, func, key, value, output ready);
endinterface

### rtl/core/lfu_out_if.sv
// Output channel: one result per transaction.
interface lfu_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] read_value;
  modport source (output valid, found, read_value, input ready);
  modport sink   (input valid, found, read_value, output ready);
endinterface

### rtl/core/lfu_cfg_if.sv
// Configuration write channel carrying the capacity register.
interface lfu_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/core/lfu_cell.sv
// One cache entry cell: holds an entry and advances the search wave by one stage.
module lfu_cell #(
  parameter int IDX        = 0,
  parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  lfu_pkg::lfu_carry_t carry_in,
  input  lfu_pkg::lfu_cmd_t   cmd,
  output lfu_pkg::lfu_carry_t carry_out
);

  localparam logic [lfu_pkg::SLOT_FIELD_W-1:0] MY_SLOT = (lfu_pkg::SLOT_FIELD_W)'(IDX);

  logic                  valid;
  logic [31:0]           key;
  logic [31:0]           value;
  logic [COUNT_BITS-1:0] count;
  logic [63:0]           stamp;
  lfu_pkg::lfu_carry_t   carry_next;
  logic [31:0]           count_ext;

  assign count_ext = 32'(count);

  always_comb begin
    carry_next = carry_in;
    if (valid && !carry_in.hit && key == carry_in.key) begin
      carry_next.hit       = 1'b1;
      carry_next.hit_slot  = MY_SLOT;
      carry_next.hit_value = value;
    end
    if (valid && (!carry_in.best_ok || count_ext < carry_in.best_count ||
        (count_ext == carry_in.best_count && stamp < carry_in.best_stamp))) begin
      carry_next.best_ok    = 1'b1;
      carry_next.best_slot  = MY_SLOT;
      carry_next.best_count = count_ext;
      carry_next.best_stamp = stamp;
    end
    if (!valid && !carry_in.free_ok) begin
      carry_next.free_ok   = 1'b1;
      carry_next.free_slot = MY_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.slot == MY_SLOT) begin
      case (cmd.op)
        lfu_pkg::OP_BUMP, lfu_pkg::OP_WRITE: begin
          if (count != '1) begin
            count <= count + 1'b1;
          end
          stamp <= cmd.stamp;
          if (cmd.op == lfu_pkg::OP_WRITE) begin
            value <= cmd.value;
          end
        end
        lfu_pkg::OP_INSERT: begin
          valid <= 1'b1;
          key   <= cmd.key;
          value <= cmd.value;
          count <= COUNT_BITS'(1);
          stamp <= cmd.stamp;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/core/lfu_cache_lru_tiebreak_top.sv
// Top level of the LFU cache: cell row, sequencer and result register.
// The result is registered once the search wave has passed every entry cell and the update is
// decided. A new input is accepted only in idle, so only one item is in the cell row at a time;
// the wave steps one entry cell per cycle; a result held by out ready delays the next accept.
// Reset (rst, synchronous): all entries invalid, occupancy and stamp counter zero,
// capacity 16; no clearing pass is needed; both input channels are not ready in reset.
module lfu_cache_lru_tiebreak_top #(
  parameter int ENTRIES    = lfu_pkg::DEF_ENTRIES,
  parameter int COUNT_BITS = lfu_pkg::DEF_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  lfu_in_if.sink     in_ch,
  lfu_out_if.source  out_ch,
  lfu_cfg_if.sink    cfg
);

  localparam int OCC_W = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t                      state, state_next;
  lfu_pkg::lfu_carry_t         chain [ENTRIES+1];
  lfu_pkg::lfu_carry_t         scan;
  lfu_pkg::lfu_cmd_t           cmd;
  logic [lfu_pkg::CAP_W-1:0]   capacity;
  logic [OCC_W-1:0]            cap_eff;
  logic [OCC_W-1:0]            occupied;
  logic                        occ_inc;
  logic [63:0]                 order_counter;
  logic                        func_q;
  logic [31:0]                 value_q;
  logic                        fire;
  logic                        accept;
  logic [31:0]                 res_value;
  logic                        out_valid;

  assign in_ch.ready = (state == S_IDLE) && !rst;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cfg.ready   = !rst;
  assign fire        = (state == S_DECIDE) && (!out_valid || out_ch.ready);
  assign cap_eff     = (int'(capacity) >= ENTRIES) ? OCC_W'(ENTRIES) : OCC_W'(capacity);

  always_comb begin
    chain[0]      = '0;
    chain[0].live = accept;
    chain[0].key  = in_ch.key;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfu_cell #(.IDX(i), .COUNT_BITS(COUNT_BITS)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .carry_in  (chain[i]),
      .cmd       (cmd),
      .carry_out (chain[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (chain[ENTRIES].live) state_next = S_DECIDE;
      S_DECIDE: if (fire) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Decide the update once the search wave has passed every cell.
  always_comb begin
    cmd       = '0;
    cmd.op    = lfu_pkg::OP_NONE;
    cmd.key   = scan.key;
    cmd.value = value_q;
    cmd.stamp = order_counter;
    occ_inc   = 1'b0;
    if (func_q == lfu_pkg::FUNC_READ) begin
      res_value = scan.hit ? scan.hit_value : '1;
    end else begin
      res_value = '0;
    end
    if (fire) begin
      if (func_q == lfu_pkg::FUNC_READ) begin
        if (scan.hit) begin
          cmd.op   = lfu_pkg::OP_BUMP;
          cmd.slot = scan.hit_slot;
        end
      end else if (cap_eff != '0) begin
        if (scan.hit) begin
          cmd.op   = lfu_pkg::OP_WRITE;
          cmd.slot = scan.hit_slot;
        end else if (occupied >= cap_eff) begin
          if (scan.best_ok) begin
            cmd.op   = lfu_pkg::OP_INSERT;
            cmd.slot = scan.best_slot;
          end
        end else if (scan.free_ok) begin
          cmd.op   = lfu_pkg::OP_INSERT;
          cmd.slot = scan.free_slot;
          occ_inc  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      capacity      <= lfu_pkg::CAP_RESET;
      occupied      <= '0;
      order_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        capacity <= cfg.data;
      end
      if (occ_inc) begin
        occupied <= occupied + 1'b1;
      end
      if (cmd.op != lfu_pkg::OP_NONE) begin
        order_counter <= order_counter + 64'd1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= in_ch.func;
      value_q <= in_ch.value;
    end
    if (state == S_SCAN && chain[ENTRIES].live) begin
      scan <= chain[ENTRIES];
    end
    if (fire) begin
      out_ch.found      <= scan.hit;
      out_ch.read_value <= res_value;
    end
  end

  assign out_ch.valid = out_valid;

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    int'(occupied) <= ENTRIES)
    else $error("occupancy exceeds entry count");

  a_wave_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[ENTRIES].live |-> state == S_SCAN)
    else $error("search wave finished outside scan");

  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("decided item produced no result");

  a_insert_no_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.op == lfu_pkg::OP_INSERT |-> !scan.hit && func_q == lfu_pkg::FUNC_WRITE)
    else $error("insert issued on a hit or a read");
`endif

endmodule
